[hdl/ravsf_pkg.sv]
// ----------------------------------------------------------------------------
// ravsf_pkg
// Shared constants, item type and back-end state codes for the roll angle
// slew limiter with moving average.
// ----------------------------------------------------------------------------
package ravsf_pkg;

  // sample and angle widths
  localparam int ROLL_W  = 16;
  localparam int STEP_W  = 15;

  // averaging window and the widths that follow from it
  localparam int WINDOW  = 8;
  localparam int PTR_W   = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int TOT_W   = ROLL_W + $clog2(WINDOW);
  localparam int DCNT_W  = $clog2(TOT_W);

  // radians*8192 to degrees*128, Q16 scale
  localparam int SCALE_W = 16;
  localparam logic [SCALE_W-1:0] DEG_SCALE = 16'd58671;
  localparam int MAG_W   = ROLL_W + 1;
  localparam int PROD_W  = MAG_W + SCALE_W;

  // pi/2 * 8192, rounded up
  localparam logic signed [ROLL_W-1:0] QUARTER_TURN = 16'sd12868;

  localparam logic [STEP_W-1:0] MAX_STEP_RESET = 15'd1920;

  // front-to-back queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // one classified sample on its way to the averaging engine
  typedef struct packed {
    logic                     missing;
    logic                     clipped;
    logic signed [ROLL_W-1:0] deg;
  } item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ACCUM,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

[hdl/ravsf_front.sv]
// ----------------------------------------------------------------------------
// ravsf_front
// Accepts samples, applies the heading flip, converts to degrees*128 and
// clips the change against the previous limited value.
// ----------------------------------------------------------------------------
module ravsf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [ravsf_pkg::STEP_W-1:0] cfg_wr_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ravsf_pkg::ROLL_W-1:0] roll_i,
  input  logic [ravsf_pkg::ROLL_W-1:0] yaw_i,
  input  logic                        missing_i,
  output logic                        push_o,
  output ravsf_pkg::item_t            item_o,
  input  logic                        full_i
);
  import ravsf_pkg::*;

  logic [STEP_W-1:0]        max_step_q;
  logic                     s1_valid_q;
  logic                     s1_missing_q;
  logic                     s1_neg_q;
  logic [PROD_W-1:0]        s1_prod_q;
  logic signed [ROLL_W-1:0] prev_q, prev_d;
  logic                     first_q;

  logic signed [ROLL_W-1:0] roll_s, yaw_s;
  logic                     flip;
  logic signed [MAG_W-1:0]  roll_f;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W:0]          rounded;
  logic signed [ROLL_W+1:0] deg_e, prev_e, step_e, change, lim;
  logic                     clip;
  logic                     accept;

  // max step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= MAX_STEP_RESET;
    end else if (cfg_wr_en_i) begin
      max_step_q <= cfg_wr_data_i;
    end
  end

  // stage 1: heading flip and magnitude, then scale
  always_comb begin
    roll_s = $signed(roll_i);
    yaw_s  = $signed(yaw_i);
    flip   = (yaw_s >= QUARTER_TURN) || (yaw_s <= -QUARTER_TURN);
    roll_f = flip ? -{roll_s[ROLL_W-1], roll_s} : {roll_s[ROLL_W-1], roll_s};
    mag    = roll_f[MAG_W-1] ? $unsigned(-roll_f) : $unsigned(roll_f);
  end

  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_missing_q <= missing_i;
      s1_neg_q     <= roll_f[MAG_W-1];
      s1_prod_q    <= mag * DEG_SCALE;
    end
  end

  // stage 2: round to nearest, restore sign, clip against previous value
  always_comb begin
    rounded = {1'b0, s1_prod_q} + (PROD_W+1)'(32768);
    deg_e   = s1_neg_q ? -$signed({2'b00, rounded[31:16]})
                       :  $signed({2'b00, rounded[31:16]});
    prev_e  = {{2{prev_q[ROLL_W-1]}}, prev_q};
    step_e  = $signed({3'b000, max_step_q});
    change  = deg_e - prev_e;
    lim     = deg_e;
    clip    = 1'b0;
    if (!first_q) begin
      if (change > step_e) begin
        lim  = prev_e + step_e;
        clip = 1'b1;
      end else if (change < -step_e) begin
        lim  = prev_e - step_e;
        clip = 1'b1;
      end
    end
    // saturate to 16 bits
    if (lim > 18'sd32767) begin
      prev_d = 16'sh7FFF;
    end else if (lim < -18'sd32768) begin
      prev_d = 16'sh8000;
    end else begin
      prev_d = lim[ROLL_W-1:0];
    end
    item_o.missing = s1_missing_q;
    item_o.clipped = clip && !s1_missing_q;
    item_o.deg     = prev_d;
  end

  // hold previous value and first flag; a missing sample leaves them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      first_q <= 1'b1;
    end else if (push_o && !s1_missing_q) begin
      prev_q  <= prev_d;
      first_q <= 1'b0;
    end
  end

endmodule

[hdl/ravsf_queue.sv]
// ----------------------------------------------------------------------------
// ravsf_queue
// Short first-in first-out queue between the front and the averaging engine.
// ----------------------------------------------------------------------------
module ravsf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ravsf_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output ravsf_pkg::item_t item_o,
  output logic             empty_o
);
  import ravsf_pkg::*;

  item_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue popped while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

[hdl/ravsf_back.sv]
// ----------------------------------------------------------------------------
// ravsf_back
// Averaging engine: updates the history ring and running total, divides
// the total by the fill count one quotient bit per cycle, holds the result.
// ----------------------------------------------------------------------------
module ravsf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  ravsf_pkg::item_t            item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ravsf_pkg::ROLL_W-1:0] mean_roll_o,
  output logic                        step_limited_o
);
  import ravsf_pkg::*;

  back_state_e              state_q, state_d;
  item_t                    item_q, item_d;
  logic signed [TOT_W-1:0]  total_q, total_d;
  logic [PTR_W-1:0]         wptr_q, wptr_d;
  logic                     full_q, full_d;
  logic [DCNT_W-1:0]        div_cnt_q, div_cnt_d;
  logic [TOT_W-1:0]         quo_q, quo_d;
  logic [CNT_W-1:0]         rem_q, rem_d;
  logic [CNT_W-1:0]         divisor_q, divisor_d;
  logic                     neg_q, neg_d;
  logic [ROLL_W-1:0]        res_q, res_d;
  logic                     clip_q, clip_d;

  logic [ROLL_W-1:0]        ring_q [WINDOW];
  logic [ROLL_W-1:0]        rd_data_q;
  logic                     ring_we;

  logic signed [TOT_W-1:0]  old_e, new_e;
  logic [CNT_W:0]           shifted;
  logic                     ge;
  logic signed [TOT_W:0]    signed_q;

  // history ring; the read at the write pointer lands before ACCUM
  always_ff @(posedge clk_i) begin
    rd_data_q <= ring_q[wptr_q];
    if (ring_we) begin
      ring_q[wptr_q] <= item_q.deg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      total_q <= '0;
      wptr_q  <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      wptr_q  <= wptr_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    div_cnt_q <= div_cnt_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
    clip_q    <= clip_d;
  end

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    total_d   = total_q;
    wptr_d    = wptr_q;
    full_d    = full_q;
    div_cnt_d = div_cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    neg_d     = neg_q;
    res_d     = res_q;
    clip_d    = clip_q;
    pop_o     = 1'b0;
    ring_we   = 1'b0;
    out_valid_o = 1'b0;

    old_e    = full_q ? $signed({{(TOT_W-ROLL_W){rd_data_q[ROLL_W-1]}}, rd_data_q}) : '0;
    new_e    = $signed({{(TOT_W-ROLL_W){item_q.deg[ROLL_W-1]}}, item_q.deg});
    shifted  = {rem_q, quo_q[TOT_W-1]};
    ge       = shifted >= {1'b0, divisor_q};
    signed_q = '0;

    unique case (state_q)
      B_IDLE: begin
        // take the next item; a missing sample answers zero at once
        if (!empty_i) begin
          pop_o  = 1'b1;
          item_d = item_i;
          if (item_i.missing) begin
            res_d   = '0;
            clip_d  = 1'b0;
            state_d = B_OUT;
          end else begin
            state_d = B_ACCUM;
          end
        end
      end
      B_ACCUM: begin
        // drop the oldest entry once full, add the new one, advance
        ring_we = 1'b1;
        total_d = total_q - old_e + new_e;
        if (wptr_q == PTR_W'(WINDOW - 1)) begin
          wptr_d = '0;
          full_d = 1'b1;
        end else begin
          wptr_d = wptr_q + PTR_W'(1);
        end
        divisor_d = full_d ? CNT_W'(WINDOW) : CNT_W'(wptr_d);
        neg_d     = total_d[TOT_W-1];
        quo_d     = total_d[TOT_W-1] ? $unsigned(-total_d) : $unsigned(total_d);
        rem_d     = '0;
        div_cnt_d = '0;
        clip_d    = item_q.clipped;
        state_d   = B_DIV;
      end
      B_DIV: begin
        // one restoring step per cycle on the magnitude
        rem_d     = ge ? CNT_W'(shifted - {1'b0, divisor_q}) : shifted[CNT_W-1:0];
        quo_d     = {quo_q[TOT_W-2:0], ge};
        div_cnt_d = div_cnt_q + DCNT_W'(1);
        if (div_cnt_q == DCNT_W'(TOT_W - 1)) begin
          signed_q = neg_q ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
          if (signed_q > (TOT_W+1)'(32767)) begin
            res_d = 16'h7FFF;
          end else if (signed_q < -$signed((TOT_W+1)'(32768))) begin
            res_d = 16'h8000;
          end else begin
            res_d = signed_q[ROLL_W-1:0];
          end
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        // hold the result until the beat is taken
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign mean_roll_o    = res_q;
  assign step_limited_o = clip_q;

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("ring full flag fell without reset");

endmodule

[hdl/roll_angle_slew_average_filter_unit.sv]
// Path: a sample's result beat is offered after the front register, the queue,
//   the ring update and the bit-serial divider over the 19-bit total;
//   a missing sample's zero beat skips the ring update and the divider.
// Pacing: the back end pops a new item only after the last result beat is taken
//   (pop, ring update, divider steps, output beat); a missing sample skips the divider.
// Reset: max_step returns to 1920, the first flag sets, previous value, pointer,
//   fill flag and total clear at once; ring entries are read only after written.
// ----------------------------------------------------------------------------
// roll_angle_slew_average_filter_unit
// Roll angle slew limiter with moving average over the last WINDOW samples.
// ----------------------------------------------------------------------------
module roll_angle_slew_average_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [14:0] cfg_wr_data_i,   // max_step
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [15:0] roll_sample, [31:16] yaw_sample
  input  logic        s_axis_tuser,    // sample_missing
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [15:0] mean_roll
  output logic        m_axis_tuser     // step_limited
);
  import ravsf_pkg::*;

  logic  push, full, pop, empty;
  item_t front_item, queue_item;

  ravsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .roll_i        (s_axis_tdata[15:0]),
    .yaw_i         (s_axis_tdata[31:16]),
    .missing_i     (s_axis_tuser),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  ravsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  ravsf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .item_i         (queue_item),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .mean_roll_o    (m_axis_tdata),
    .step_limited_o (m_axis_tuser)
  );

endmodule

[dv/tb_roll_angle_slew_average_filter_unit.sv]
// ----------------------------------------------------------------------------
// tb_roll_angle_slew_average_filter_unit
// Drives IMU roll/yaw samples into the roll angle slew limiter with moving
// average and checks every output beat against an in-bench predictor. The
// predictor tracks the previous limited roll, the first-sample flag, the
// history ring and its running total. The step limit is changed between
// phases while the block is drained. Both stream sides idle and stall at
// random, apart from one long stretch with no idling.
// ----------------------------------------------------------------------------
module tb_roll_angle_slew_average_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ravsf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int QUIET_FROM  = 15000;
  localparam int QUIET_TO    = 25000;
  localparam int IDLE_PCT    = 7;
  localparam int PHASE_ITEMS = 255;

  // one sensor sample as it goes into the block
  typedef struct packed {
    logic signed [ROLL_W-1:0] roll;
    logic signed [ROLL_W-1:0] yaw;
    logic                     missing;
  } imu_sample_t;

  // one averaged result as it comes out of the block
  typedef struct packed {
    logic signed [ROLL_W-1:0] mean;
    logic                     clipped;
  } roll_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_wr_en_i   = 1'b0;
  logic [STEP_W-1:0] cfg_wr_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tuser;

  roll_angle_slew_average_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // stimulus and expectation stores
  imu_sample_t  pending_samples[$];
  roll_result_t expected_means[$];
  imu_sample_t  in_flight;
  roll_result_t seen_beat;
  roll_result_t wanted_beat;

  // predictor state
  logic [STEP_W-1:0] step_limit = MAX_STEP_RESET;
  int  last_limited   = 0;
  bit  awaiting_first = 1'b1;
  int  ring_entries[WINDOW];
  int  ring_slot      = 0;
  bit  ring_is_full   = 1'b0;
  int  ring_sum       = 0;

  // bookkeeping
  int cycle_count   = 0;
  int error_count   = 0;
  int samples_sent  = 0;
  int missing_sent  = 0;
  int clipped_count = 0;
  int beats_checked = 0;
  int settings_used = 1;
  int walk_roll     = 0;
  bit heading_back  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // end the run if the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_means.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit idle_now();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // compute the result of one accepted beat and queue it
  task automatic predict_beat(input imu_sample_t s);
    int roll;
    int mag;
    int deg;
    int change;
    int fill;
    roll_result_t r;
    r = '0;
    samples_sent++;
    if (s.missing) begin
      missing_sent++;
    end else begin
      // flip roll when heading points backward, then scale to deg*128
      roll = s.roll;
      if (s.yaw >= QUARTER_TURN || s.yaw <= -QUARTER_TURN) roll = -roll;
      mag = (roll < 0) ? -roll : roll;
      deg = int'((longint'(mag) * longint'(DEG_SCALE) + 64'sd32768) >>> 16);
      if (roll < 0) deg = -deg;
      // clip the change against the last limited value
      if (!awaiting_first) begin
        change = deg - last_limited;
        if (change > int'(step_limit)) begin
          deg = last_limited + int'(step_limit);
          r.clipped = 1'b1;
        end else if (change < -int'(step_limit)) begin
          deg = last_limited - int'(step_limit);
          r.clipped = 1'b1;
        end
      end
      deg = clamp16(deg);
      last_limited   = deg;
      awaiting_first = 1'b0;
      // replace the oldest ring entry and average over the filled part
      if (ring_is_full) ring_sum -= ring_entries[ring_slot];
      ring_entries[ring_slot] = deg;
      ring_sum += deg;
      if (ring_slot == WINDOW - 1) begin
        ring_slot    = 0;
        ring_is_full = 1'b1;
      end else begin
        ring_slot++;
      end
      fill = ring_is_full ? WINDOW : ring_slot;
      r.mean = 16'(clamp16(ring_sum / fill));
      if (r.clipped) clipped_count++;
    end
    expected_means.push_back(r);
  endtask

  // driver: hand out queued samples, one beat per handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_beat(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && !idle_now()) begin
          in_flight = pending_samples.pop_front();
          s_axis_tdata  <= {in_flight.yaw, in_flight.roll};
          s_axis_tuser  <= in_flight.missing;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: stall at random and check each output beat in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_beat.mean    = m_axis_tdata;
        seen_beat.clipped = m_axis_tuser;
        if (expected_means.size() == 0) begin
          flag_error($sformatf("unexpected beat: roll %0d limited %0b",
                               seen_beat.mean, seen_beat.clipped));
        end else begin
          wanted_beat = expected_means.pop_front();
          if (seen_beat.mean !== wanted_beat.mean ||
              seen_beat.clipped !== wanted_beat.clipped) begin
            flag_error($sformatf(
              "beat %0d: expected roll %0d limited %0b, got roll %0d limited %0b",
              beats_checked, wanted_beat.mean, wanted_beat.clipped,
              seen_beat.mean, seen_beat.clipped));
          end
        end
        beats_checked++;
      end
      m_axis_tready <= !idle_now();
    end
  end

  task automatic add_sample(input int roll, input int yaw, input bit missing);
    imu_sample_t s;
    s.roll    = 16'(roll);
    s.yaw     = 16'(yaw);
    s.missing = missing;
    pending_samples.push_back(s);
  endtask

  // hold until every queued sample has been sent and answered
  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_means.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_max_step(input logic [STEP_W-1:0] v);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    step_limit = v;
    settings_used++;
  endtask

  // mix of smooth roll walks and wild jumps
  task automatic add_random_samples(input int n);
    int yaw;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(49) == 0) heading_back = !heading_back;
      if ($urandom_range(3) == 0) begin
        yaw = int'($urandom_range(51472)) - 25736;
        add_sample(int'($urandom_range(65535)) - 32768, yaw, $urandom_range(9) == 0);
      end else begin
        walk_roll = clamp16(walk_roll + int'($urandom_range(1600)) - 800);
        if (heading_back) begin
          yaw = int'($urandom_range(25736, 12868));
          if ($urandom_range(1)) yaw = -yaw;
        end else begin
          yaw = int'($urandom_range(25734)) - 12867;
        end
        add_sample(walk_roll, yaw, $urandom_range(11) == 0);
      end
    end
  endtask

  initial begin
    logic [STEP_W-1:0] step_plan[6];
    step_plan = '{15'd0, 15'd23040, STEP_W'($urandom_range(23040)), 15'd1,
                  STEP_W'($urandom_range(3000)), MAX_STEP_RESET};

    // directed: missing before the first sample, field extremes, heading edge
    add_sample(-32768, 25736, 1'b1);
    add_sample(32767, 0, 1'b0);
    add_sample(-32768, 0, 1'b0);
    add_sample(-32768, 12868, 1'b0);
    add_sample(1000, 12867, 1'b0);
    add_sample(1000, -12868, 1'b0);
    add_sample(1000, -12867, 1'b0);
    add_sample(0, 25736, 1'b0);
    add_sample(-1, -25736, 1'b0);
    add_sample(1, 0, 1'b0);
    add_sample(0, 0, 1'b1);
    // negative ramp past one ring wrap, means truncate toward zero
    for (int k = 1; k <= 11; k++) add_sample(-37 * k - 3, 100 * k, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // one random phase per step limit setting
    foreach (step_plan[p]) begin
      write_max_step(step_plan[p]);
      add_random_samples(PHASE_ITEMS);
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d beats: %0d missing, %0d slew-clipped",
             samples_sent, beats_checked, missing_sent, clipped_count);
    $display("Used %0d step limit settings over %0d cycles, %0d mismatches",
             settings_used, cycle_count, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
